// File: hdl/fresnel_dielectric_reflectance_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Fresnel reflectance unit
// Shorthands for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_UNIT_DEFINES_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fdr_pkg.sv
// ---------------------------------------------------------------------------
// Fresnel reflectance package
// Shared constants, register codes and the pipeline payload type.
// ---------------------------------------------------------------------------
package fdr_pkg;

  // Fixed-point unit values.
  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Reset values of the index registers (Q4.12).
  localparam logic [15:0] ETA_I_RST = 16'd4096;
  localparam logic [15:0] ETA_T_RST = 16'd6144;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_ETA_INCIDENT = 1'b0,
    CFG_ETA_TRANSMIT = 1'b1
  } cfg_idx_e;

  // Stage map of the pipeline.
  localparam int S_MUL  = 1;          // index and cosine squares
  localparam int S_LHS  = 2;          // ei^2 * sin^2
  localparam int S_CMP  = 3;          // total internal reflection test
  localparam int S_QD0  = 4;          // first stage of the sin^2 divider
  localparam int QD_N   = 15;         // 30 quotient bits, two per stage
  localparam int S_SQ0  = S_QD0 + QD_N;
  localparam int SQ_N   = 8;          // 16 root iterations, two per stage
  localparam int S_PQ   = S_SQ0 + SQ_N;
  localparam int S_DD   = S_PQ + 1;   // sums and differences
  localparam int S_RD0  = S_DD + 1;   // first stage of the ratio dividers
  localparam int RD_N   = 16;         // 31 quotient bits, two per stage
  localparam int RD_BITS = 31;
  localparam int S_SQR  = S_RD0 + RD_N;
  localparam int S_SUM  = S_SQR + 1;
  localparam int NST    = S_SUM + 1;

  // Everything one beat carries down the pipeline.
  typedef struct packed {
    logic        tir;
    logic [15:0] ei;
    logic [15:0] et;
    logic [15:0] ci;
    logic [30:0] s2;
    logic [31:0] ei2;
    logic [31:0] et2;
    logic [62:0] lhs;
    logic [33:0] rem;
    logic [29:0] quo;
    logic [31:0] sv;
    logic [31:0] sr;
    logic [31:0] p1;
    logic [31:0] q1;
    logic [31:0] p2;
    logic [31:0] q2;
    logic [32:0] den1;
    logic [32:0] den2;
    logic [33:0] r1;
    logic [33:0] r2;
    logic [30:0] rt1;
    logic [30:0] rt2;
    logic [61:0] sq1;
    logic [61:0] sq2;
    logic [15:0] refl;
  } pl_t;

endpackage

// File: hdl/fresnel_dielectric_reflectance_unit.sv
// ---------------------------------------------------------------------------
// Fresnel dielectric reflectance unit
// Unpolarized reflectance of a dielectric boundary from a signed cosine.
// ---------------------------------------------------------------------------
// The unit accepts one cosine beat per cycle and presents the reflectances in
// order through its 47-stage pipeline: the 30-bit divider for the refracted
// sine, the 16-step square root and the two 31-bit ratio dividers each resolve
// two bits per stage. Stages advance on their own, so bubbles close up while
// the output is held; the input stalls only once all 47 stages hold a beat
// and the output is blocked.
module fresnel_dielectric_reflectance_unit
  import fdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] cos_incident_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] reflectance_o,
  output logic        total_internal_o
);

  logic [15:0] eta_i_q, eta_t_q;
  pl_t         st_q [NST];
  pl_t         st_d [NST];
  logic [NST-1:0] v_q;
  logic [NST-1:0] adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_i_q <= ETA_I_RST;
      eta_t_q <= ETA_T_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ETA_INCIDENT: eta_i_q <= cfg_data_i;
        CFG_ETA_TRANSMIT: eta_t_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    adv[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st

    // Payload register of this stage.
    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end

    if (k == 0) begin : g_in
      // Swap the indices for a ray leaving the medium and take |cos|.
      always_comb begin : c_in
        logic pos;
        pos = !cos_incident_i[15] && (cos_incident_i != 16'd0);
        st_d[k]    = '0;
        st_d[k].ei = pos ? eta_i_q : eta_t_q;
        st_d[k].et = pos ? eta_t_q : eta_i_q;
        st_d[k].ci = pos ? cos_incident_i : (~cos_incident_i + 16'd1);
      end
    end else if (k == S_MUL) begin : g_mul
      // Squares of the indices and sin^2 of the incident angle.
      always_comb begin
        st_d[k]     = st_q[k-1];
        st_d[k].ei2 = 32'(st_q[k-1].ei) * 32'(st_q[k-1].ei);
        st_d[k].et2 = 32'(st_q[k-1].et) * 32'(st_q[k-1].et);
        st_d[k].s2  = ONE_Q30 - 31'(32'(st_q[k-1].ci) * 32'(st_q[k-1].ci));
      end
    end else if (k == S_LHS) begin : g_lhs
      always_comb begin
        st_d[k]     = st_q[k-1];
        st_d[k].lhs = 63'(st_q[k-1].ei2) * 63'(st_q[k-1].s2);
      end
    end else if (k == S_CMP) begin : g_cmp
      // Total internal reflection test; seed the divider remainder.
      always_comb begin
        st_d[k]     = st_q[k-1];
        st_d[k].tir = st_q[k-1].lhs >= {1'b0, st_q[k-1].et2, 30'd0};
        st_d[k].rem = {1'b0, st_q[k-1].lhs[62:30]};
        st_d[k].quo = '0;
      end
    end else if (k >= S_QD0 && k < S_SQ0) begin : g_qd
      // Restoring division of ei^2 * sin^2 by et^2, two bits a stage.
      always_comb begin : c_qd
        pl_t x;
        logic [33:0] r;
        x = st_q[k-1];
        for (int t = 0; t < 2; t++) begin
          r     = {x.rem[32:0], x.lhs[29]};
          x.lhs = {x.lhs[61:0], 1'b0};
          if (r >= {2'b00, x.et2}) begin
            x.rem = r - {2'b00, x.et2};
            x.quo = {x.quo[28:0], 1'b1};
          end else begin
            x.rem = r;
            x.quo = {x.quo[28:0], 1'b0};
          end
        end
        st_d[k] = x;
      end
    end else if (k >= S_SQ0 && k < S_PQ) begin : g_sq
      // Digit-by-digit square root of cos^2 of the refracted angle.
      always_comb begin : c_sq
        pl_t x;
        logic [31:0] bitv;
        x = st_q[k-1];
        if (k == S_SQ0) begin
          x.sv = {1'b0, ONE_Q30} - {2'b00, x.quo};
          x.sr = '0;
        end
        for (int t = 0; t < 2; t++) begin
          bitv = 32'h4000_0000 >> (2 * ((k - S_SQ0) * 2 + t));
          if (x.sv >= x.sr + bitv) begin
            x.sv = x.sv - (x.sr + bitv);
            x.sr = (x.sr >> 1) + bitv;
          end else begin
            x.sr = x.sr >> 1;
          end
        end
        st_d[k] = x;
      end
    end else if (k == S_PQ) begin : g_pq
      // Index-cosine products of both polarizations.
      always_comb begin
        st_d[k]    = st_q[k-1];
        st_d[k].p1 = 32'(st_q[k-1].et) * 32'(st_q[k-1].ci);
        st_d[k].q1 = 32'(st_q[k-1].ei) * 32'(st_q[k-1].sr[15:0]);
        st_d[k].p2 = 32'(st_q[k-1].ei) * 32'(st_q[k-1].ci);
        st_d[k].q2 = 32'(st_q[k-1].et) * 32'(st_q[k-1].sr[15:0]);
      end
    end else if (k == S_DD) begin : g_dd
      // Sums as divisors, absolute differences as dividends.
      always_comb begin : c_dd
        pl_t x;
        x      = st_q[k-1];
        x.den1 = {1'b0, x.p1} + {1'b0, x.q1};
        x.den2 = {1'b0, x.p2} + {1'b0, x.q2};
        x.r1   = {2'b00, (x.p1 > x.q1) ? (x.p1 - x.q1) : (x.q1 - x.p1)};
        x.r2   = {2'b00, (x.p2 > x.q2) ? (x.p2 - x.q2) : (x.q2 - x.p2)};
        x.rt1  = '0;
        x.rt2  = '0;
        st_d[k] = x;
      end
    end else if (k >= S_RD0 && k < S_SQR) begin : g_rd
      // Two ratio dividers in lockstep, quotient in Q30.
      always_comb begin : c_rd
        pl_t x;
        x = st_q[k-1];
        for (int t = 0; t < 2; t++) begin
          if ((k - S_RD0) * 2 + t < RD_BITS) begin
            if (x.r1 >= {1'b0, x.den1}) begin
              x.r1  = x.r1 - {1'b0, x.den1};
              x.rt1 = {x.rt1[29:0], 1'b1};
            end else begin
              x.rt1 = {x.rt1[29:0], 1'b0};
            end
            x.r1 = {x.r1[32:0], 1'b0};
            if (x.r2 >= {1'b0, x.den2}) begin
              x.r2  = x.r2 - {1'b0, x.den2};
              x.rt2 = {x.rt2[29:0], 1'b1};
            end else begin
              x.rt2 = {x.rt2[29:0], 1'b0};
            end
            x.r2 = {x.r2[32:0], 1'b0};
          end
        end
        st_d[k] = x;
      end
    end else if (k == S_SQR) begin : g_sqr
      // Squared ratios; a zero divisor counts as a ratio of one.
      always_comb begin : c_sqr
        pl_t x;
        logic [30:0] e1, e2;
        x   = st_q[k-1];
        e1  = (x.den1 == '0) ? ONE_Q30 : x.rt1;
        e2  = (x.den2 == '0) ? ONE_Q30 : x.rt2;
        x.sq1 = 62'(e1) * 62'(e1);
        x.sq2 = 62'(e2) * 62'(e2);
        st_d[k] = x;
      end
    end else begin : g_sum
      // Half the sum rounded to Q15, saturated, forced on reflection.
      always_comb begin : c_sum
        pl_t x;
        logic [62:0] sum;
        x   = st_q[k-1];
        sum = {1'b0, x.sq1} + {1'b0, x.sq2} + (63'd1 << 45);
        if (x.tir || sum[62:46] > {1'b0, ONE_Q15}) begin
          x.refl = ONE_Q15;
        end else begin
          x.refl = sum[61:46];
        end
        st_d[k] = x;
      end
    end
  end

  assign out_valid_o      = v_q[NST-1];
  assign reflectance_o    = st_q[NST-1].refl;
  assign total_internal_o = st_q[NST-1].tir;

endmodule

// File: hdl/fdr_checker.sv
// ---------------------------------------------------------------------------
// Fresnel reflectance port checker
// Watches the ports of the unit and flags beats that break its promises.
// ---------------------------------------------------------------------------
`include "fresnel_dielectric_reflectance_unit_defines.svh"

module fdr_checker
  import fdr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] reflectance_o,
  input logic        total_internal_o
);

  // A held result stays valid until taken.
  `FDR_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // Reflectance never exceeds one.
  `FDR_ASSERT_NOW(a_refl_max, out_valid_o, reflectance_o <= ONE_Q15, "reflectance above one")

  // Total internal reflection always reports exactly one.
  `FDR_ASSERT_NOW(a_tir_one, out_valid_o && total_internal_o, reflectance_o == ONE_Q15,
    "reflection flag without full reflectance")

  // When the output side takes a beat, the input side is never blocked.
  `FDR_ASSERT_NOW(a_ready_flow, out_ready_i, in_ready_o, "input stalled while output drains")

endmodule

bind fresnel_dielectric_reflectance_unit fdr_checker u_fdr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .reflectance_o    (reflectance_o),
  .total_internal_o (total_internal_o)
);
